>>> rtl/gdc_pkg.sv
// ----------------------------------------------------------------------------
// gdc_pkg: shared types, constants and tables for the Gregorian date converter
// Word layouts for both channels, reciprocal constants and month tables.
// ----------------------------------------------------------------------------
package gdc_pkg;

    localparam int YEAR_BITS   = 14;
    localparam int MONTH_BITS  = 4;
    localparam int DAY_BITS    = 5;
    localparam int WDAY_BITS   = 3;
    localparam int YDAY_BITS   = 9;
    localparam int EPOCH_BITS  = 23;

    localparam int FIRST_YEAR   = 1583;
    localparam int LEAPS_BEFORE = 383;   // leap years in 1..1582
    localparam int DAYS_IN_YEAR = 365;
    localparam int MONTHS       = 12;

    localparam logic [MONTH_BITS-1:0] MONTH_JAN = MONTH_BITS'(0);
    localparam logic [MONTH_BITS-1:0] MONTH_FEB = MONTH_BITS'(1);
    localparam logic [MONTH_BITS-1:0] MONTH_MAR = MONTH_BITS'(2);

    // y/100 as (y * DIV100_MUL) >> DIV100_SHIFT, exact for y below 2**17
    localparam int DIV100_SHIFT = 24;
    localparam int DIV100_MUL   = 167773;
    localparam int DIV100_MBITS = 18;
    localparam int Q100_BITS    = YEAR_BITS - 6;
    localparam int P100_BITS    = YEAR_BITS + DIV100_MBITS;

    // s/7 as (s * MOD7_MUL) >> MOD7_SHIFT, exact for s below 349525
    localparam int MOD7_SHIFT   = 21;
    localparam int MOD7_MUL     = 299594;
    localparam int MOD7_MBITS   = 19;
    localparam int SUM_BITS     = YEAR_BITS + 2;
    localparam int P7_BITS      = SUM_BITS + MOD7_MBITS;

    typedef struct packed {
        logic [YEAR_BITS-1:0]  year;
        logic [MONTH_BITS-1:0] month;
        logic [DAY_BITS-1:0]   day;
    } t_in_word;

    typedef struct packed {
        logic                  valid_res;
        logic                  leap;
        logic [WDAY_BITS-1:0]  weekday;
        logic [YDAY_BITS-1:0]  year_day;
        logic [EPOCH_BITS-1:0] epoch_day;
    } t_out_word;

    // Length of a month in a common year; zero for month codes past December
    function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] m);
        logic [DAY_BITS-1:0] len;
        case (m)
            4'd1:                      len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            4'd0, 4'd2, 4'd4, 4'd6,
            4'd7, 4'd9, 4'd11:         len = 5'd31;
            default:                   len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the first of the month in a common year
    function automatic logic [YDAY_BITS-1:0] days_before(input logic [MONTH_BITS-1:0] m);
        logic [YDAY_BITS-1:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // floor(31*m/12) with March as m=1 and January/February as 11/12
    function automatic logic [4:0] wday_month_term(input logic [MONTH_BITS-1:0] m);
        logic [4:0] t;
        case (m)
            4'd0:    t = 5'd28;
            4'd1:    t = 5'd31;
            4'd2:    t = 5'd2;
            4'd3:    t = 5'd5;
            4'd4:    t = 5'd7;
            4'd5:    t = 5'd10;
            4'd6:    t = 5'd12;
            4'd7:    t = 5'd15;
            4'd8:    t = 5'd18;
            4'd9:    t = 5'd20;
            4'd10:   t = 5'd23;
            4'd11:   t = 5'd25;
            default: t = 5'd0;
        endcase
        return t;
    endfunction

endpackage

>>> rtl/gdc_in_if.sv
// ----------------------------------------------------------------------------
// gdc_in_if: date input channel
// Valid/ready handshake carrying one date word.
// ----------------------------------------------------------------------------
interface gdc_in_if import gdc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/gdc_out_if.sv
// ----------------------------------------------------------------------------
// gdc_out_if: conversion result channel
// Valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface gdc_out_if import gdc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/gdc_mod7.sv
// ----------------------------------------------------------------------------
// gdc_mod7: remainder modulo 7 by reciprocal multiplication
// Registers the product and the operand, then corrects to the remainder.
// ----------------------------------------------------------------------------
module gdc_mod7 import gdc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [SUM_BITS-1:0] i_sum,
    output logic [WDAY_BITS-1:0] o_rem
);

    logic [P7_BITS-1:0]  r_prod;
    logic [SUM_BITS-1:0] r_sum;
    logic [SUM_BITS-1:0] w_quot;
    logic [SUM_BITS-1:0] w_rem;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= P7_BITS'(i_sum) * P7_BITS'(MOD7_MUL);
            r_sum  <= i_sum;
        end
    end

    assign w_quot = SUM_BITS'(r_prod >> MOD7_SHIFT);
    // quotient times 7 as shift and subtract
    assign w_rem  = r_sum - (SUM_BITS'(w_quot << 3) - w_quot);
    assign o_rem  = w_rem[WDAY_BITS-1:0];

endmodule

>>> rtl/gregorian_date_converter_top.sv
// ----------------------------------------------------------------------------
// gregorian_date_converter_top: Gregorian date check and conversion
// Five-stage pipeline; validity, leap flag, weekday, year day, epoch day.
// ----------------------------------------------------------------------------
// Throughput: one date word per cycle; each stage holds under back-pressure.
// Reset: i_rst_n clears the stage valid bits only; no result after reset.
// Stage depth is set by the divide-by-100 and modulo-7 reciprocal multiplies.
module gregorian_date_converter_top import gdc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    gdc_in_if.sink   i_in,
    gdc_out_if.source o_out
);

    logic [5:1] r_vld;
    logic [6:1] w_rdy;

    // stage 1
    logic [YEAR_BITS-1:0]  r_s1_year;
    logic [YEAR_BITS-1:0]  r_s1_ye;
    logic [MONTH_BITS-1:0] r_s1_month;
    logic [DAY_BITS-1:0]   r_s1_day;
    logic                  r_s1_ok;
    logic [P100_BITS-1:0]  r_s1_p100;
    logic [YEAR_BITS-1:0]  n_s1_ye;

    // stage 2
    logic [YEAR_BITS-1:0]  r_s2_ye;
    logic [YEAR_BITS-1:0]  r_s2_leaps;
    logic [MONTH_BITS-1:0] r_s2_month;
    logic [DAY_BITS-1:0]   r_s2_day;
    logic [YDAY_BITS-1:0]  r_s2_yday;
    logic                  r_s2_ok;
    logic                  r_s2_leap;
    logic [Q100_BITS-1:0]  w_q100;
    logic [YEAR_BITS-1:0]  w_r100;
    logic                  w_cent;
    logic                  w_quad_cent;
    logic                  n_s2_leap;
    logic [DAY_BITS:0]     w_mlen;
    logic                  n_s2_ok;
    logic [YDAY_BITS-1:0]  n_s2_yday;
    logic [YEAR_BITS-1:0]  n_s2_leaps;

    // stage 3
    logic [SUM_BITS-1:0]   r_s3_sum;
    logic [EPOCH_BITS-1:0] r_s3_epoch;
    logic [YDAY_BITS-1:0]  r_s3_yday;
    logic                  r_s3_ok;
    logic                  r_s3_leap;
    logic [SUM_BITS-1:0]   n_s3_sum;
    logic [1:0]            w_shift_term;
    logic [31:0]           w_epoch_full;

    // stage 4
    logic [EPOCH_BITS-1:0] r_s4_epoch;
    logic [YDAY_BITS-1:0]  r_s4_yday;
    logic                  r_s4_ok;
    logic                  r_s4_leap;
    logic [WDAY_BITS-1:0]  w_wday;

    // stage 5
    t_out_word             r_out;

    // A stage loads when it is empty or its successor moves on
    always_comb begin
        w_rdy[6] = o_out.ready;
        for (int k = 5; k >= 1; k--) begin
            w_rdy[k] = ~r_vld[k] | w_rdy[k+1];
        end
    end

    assign i_in.ready = w_rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[1]) r_vld[1] <= i_in.valid;
            for (int k = 2; k <= 5; k++) begin
                if (w_rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // ---------------- stage 1: range checks, start y/100 ----------------
    assign n_s1_ye = i_in.data.year - YEAR_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_s1_year  <= i_in.data.year;
            r_s1_ye    <= n_s1_ye;
            r_s1_month <= i_in.data.month;
            r_s1_day   <= i_in.data.day;
            r_s1_ok    <= (32'(i_in.data.year) >= 32'(FIRST_YEAR)) &&
                          (32'(i_in.data.month) < 32'(MONTHS)) &&
                          (i_in.data.day != '0);
            r_s1_p100  <= P100_BITS'(n_s1_ye) * P100_BITS'(DIV100_MUL);
        end
    end

    // ---------------- stage 2: leap rule, month length, day of year ----------------
    function automatic logic [Q100_BITS-1:0] w_qsel(input logic [P100_BITS-1:0] p);
        return Q100_BITS'(p >> DIV100_SHIFT);
    endfunction

    // Work from year-1: the year is a century year when year-1 ends in 99
    assign w_q100      = w_qsel(r_s1_p100);
    assign w_r100      = r_s1_ye - YEAR_BITS'(32'(w_q100) * 32'd100);
    assign w_cent      = (w_r100 == YEAR_BITS'(99));
    assign w_quad_cent = w_cent && (w_q100[1:0] == 2'b11);
    assign n_s2_leap   = ((r_s1_year[1:0] == 2'b00) && !w_cent) || w_quad_cent;
    assign w_mlen      = {1'b0, month_len(r_s1_month)} +
                         {{DAY_BITS{1'b0}}, (r_s1_month == MONTH_FEB) && n_s2_leap};
    assign n_s2_ok     = r_s1_ok && ({1'b0, r_s1_day} <= w_mlen);
    assign n_s2_yday   = days_before(r_s1_month) + YDAY_BITS'(r_s1_day) +
                         YDAY_BITS'((r_s1_month >= MONTH_MAR) && n_s2_leap);
    // leap years in 1..year-1
    assign n_s2_leaps  = (r_s1_ye >> 2) - YEAR_BITS'(w_q100) + YEAR_BITS'(w_q100 >> 2);

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_s2_ye    <= r_s1_ye;
            r_s2_leaps <= n_s2_leaps;
            r_s2_month <= r_s1_month;
            r_s2_day   <= r_s1_day;
            r_s2_yday  <= n_s2_yday;
            r_s2_ok    <= n_s2_ok;
            r_s2_leap  <= n_s2_leap;
        end
    end

    // ---------------- stage 3: weekday sum, epoch day ----------------
    // For March on, y + y/4 - y/100 + y/400 of the year itself is
    // (year-1) + leaps(year-1) + 1 + leap
    assign w_shift_term = (r_s2_month < MONTH_MAR) ? 2'd0 : (2'd1 + 2'(r_s2_leap));
    assign n_s3_sum     = SUM_BITS'(r_s2_day) + SUM_BITS'(r_s2_ye) +
                          SUM_BITS'(r_s2_leaps) + SUM_BITS'(w_shift_term) +
                          SUM_BITS'(wday_month_term(r_s2_month));
    assign w_epoch_full = 32'(DAYS_IN_YEAR) *
                          32'(r_s2_ye - YEAR_BITS'(FIRST_YEAR - 1)) +
                          32'(r_s2_leaps) - 32'(LEAPS_BEFORE) + 32'(r_s2_yday);

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_s3_sum   <= n_s3_sum;
            r_s3_epoch <= w_epoch_full[EPOCH_BITS-1:0];
            r_s3_yday  <= r_s2_yday;
            r_s3_ok    <= r_s2_ok;
            r_s3_leap  <= r_s2_leap;
        end
    end

    // ---------------- stage 4: modulo 7 product ----------------
    gdc_mod7 u_mod7 (
        .i_clk (i_clk),
        .i_en  (w_rdy[4]),
        .i_sum (r_s3_sum),
        .o_rem (w_wday)
    );

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_s4_epoch <= r_s3_epoch;
            r_s4_yday  <= r_s3_yday;
            r_s4_ok    <= r_s3_ok;
            r_s4_leap  <= r_s3_leap;
        end
    end

    // ---------------- stage 5: output word, zero on a bad date ----------------
    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            if (r_s4_ok) begin
                r_out.valid_res <= 1'b1;
                r_out.leap      <= r_s4_leap;
                r_out.weekday   <= w_wday;
                r_out.year_day  <= r_s4_yday;
                r_out.epoch_day <= r_s4_epoch;
            end else begin
                r_out <= '0;
            end
        end
    end

    assign o_out.valid = r_vld[5];
    assign o_out.data  = r_out;

endmodule
